// ----- rtl/dcp_pkg.sv -----
package dcp_pkg;

  // Default coordinate width; offsets carry one more bit.
  localparam int COORD_WIDTH_DEF = 12;

  localparam int SCALE_W = 12;
  localparam int COLOR_W = 32;
  localparam int GRAY_W  = 8;

  // Configuration port geometry: two registers on a 32-bit data port at byte addresses 0 and 4.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_CELL_SCALE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_DIST_EN    = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1);

  // Luma weights in thousandths.
  localparam int WSUM_W = 18;
  localparam logic [WSUM_W-1:0] LUMA_R = WSUM_W'(299);
  localparam logic [WSUM_W-1:0] LUMA_G = WSUM_W'(587);
  localparam logic [WSUM_W-1:0] LUMA_B = WSUM_W'(114);

  // Division by 1000 as a multiply by ceil(2^28 / 1000); exact for sums below 2^18.
  localparam int RECIP_W     = 19;
  localparam int RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(268436);
  localparam int PROD_W      = WSUM_W + RECIP_W;

  typedef struct packed {
    logic [SCALE_W-1:0] cell_scale;
    logic               dist_en;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] first_color;
    logic [COLOR_W-1:0] second_color;
  } color_pair_t;

endpackage

// ----- rtl/dcp_if.sv -----
interface dcp_in_if #(
  parameter int COORD_WIDTH = dcp_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [COORD_WIDTH-1:0]        pixel_x;
  logic [COORD_WIDTH-1:0]        pixel_y;
  logic signed [COORD_WIDTH:0]   offset_x;
  logic signed [COORD_WIDTH:0]   offset_y;
  logic [dcp_pkg::COLOR_W-1:0]   first_color;
  logic [dcp_pkg::COLOR_W-1:0]   second_color;

  modport source (
    output valid, pixel_x, pixel_y, offset_x, offset_y, first_color, second_color,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, offset_x, offset_y, first_color, second_color,
    output ready
  );
endinterface

interface dcp_out_if;
  logic                        valid;
  logic                        ready;
  logic [dcp_pkg::COLOR_W-1:0] color_out;
  logic [dcp_pkg::GRAY_W-1:0]  gray_out;

  modport source (output valid, color_out, gray_out, input ready);
  modport sink (input valid, color_out, gray_out, output ready);
endinterface

// ----- rtl/dcp_cfg_regs.sv -----
module dcp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dcp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dcp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dcp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output dcp_pkg::cfg_t                  cfg
);
  import dcp_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;
  logic [SCALE_W-1:0]   scale_r, scale_nxt;
  logic                 dist_en_r, dist_en_nxt;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    scale_nxt   = scale_r;
    dist_en_nxt = dist_en_r;
    if (wr_en) begin
      case (idx)
        REG_CELL_SCALE: begin
          // A zero scale is held at one.
          scale_nxt = (pwdata[SCALE_W-1:0] == '0) ? SCALE_RESET : pwdata[SCALE_W-1:0];
        end
        REG_DIST_EN: begin
          dist_en_nxt = pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= SCALE_RESET;
      dist_en_r <= 1'b0;
    end else begin
      scale_r   <= scale_nxt;
      dist_en_r <= dist_en_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_CELL_SCALE: prdata = CFG_DATA_W'(scale_r);
      REG_DIST_EN:    prdata = CFG_DATA_W'(dist_en_r);
      default:        prdata = '0;
    endcase
  end

  assign cfg.cell_scale = scale_r;
  assign cfg.dist_en    = dist_en_r;

endmodule

// ----- rtl/dcp_parity_pipe.sv -----
module dcp_parity_pipe #(
  parameter int COORD_WIDTH = dcp_pkg::COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [COORD_WIDTH-1:0]      pixel_x,
  input  logic [COORD_WIDTH-1:0]      pixel_y,
  input  logic signed [COORD_WIDTH:0] offset_x,
  input  logic signed [COORD_WIDTH:0] offset_y,
  input  dcp_pkg::color_pair_t        colors_in,
  input  dcp_pkg::cfg_t               cfg,
  output logic                        out_valid,
  output logic                        out_parity,
  output dcp_pkg::color_pair_t        colors_out
);
  import dcp_pkg::*;

  localparam int SUM_W = COORD_WIDTH + 2;
  localparam int MAG_W = COORD_WIDTH + 1;
  localparam int NSTG  = MAG_W;
  localparam int REM_W = SCALE_W;

  // Index 0 is the front stage; stages 1..NSTG each resolve one quotient bit.
  logic [NSTG:0]      valid_r;
  color_pair_t        colors_r [NSTG+1];
  logic [MAG_W-1:0]   mag_r    [NSTG+1][2];
  logic [REM_W-1:0]   rem_r    [NSTG+1][2];
  logic               neg_r    [NSTG+1][2];
  logic               qbit_r   [NSTG+1][2];

  logic signed [SUM_W-1:0] sum [2];
  logic signed [SUM_W-1:0] sum_neg [2];
  logic [COORD_WIDTH-1:0]  coord [2];
  logic [COORD_WIDTH:0]    offs  [2];

  assign coord[0] = pixel_x;
  assign coord[1] = pixel_y;
  assign offs[0]  = offset_x;
  assign offs[1]  = offset_y;

  for (genvar a = 0; a < 2; a++) begin : g_front
    always_comb begin
      sum[a] = $signed({2'b00, coord[a]});
      if (cfg.dist_en) begin
        sum[a] = sum[a] + $signed({offs[a][COORD_WIDTH], offs[a]});
      end
      sum_neg[a] = -sum[a];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[0][a]  <= sum[a][SUM_W-1];
        mag_r[0][a]  <= sum[a][SUM_W-1] ? sum_neg[a][MAG_W-1:0] : sum[a][MAG_W-1:0];
        rem_r[0][a]  <= '0;
        qbit_r[0][a] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      colors_r[0] <= colors_in;
    end
  end

  // Restoring division of the magnitude by the cell scale, one bit per stage.
  for (genvar k = 1; k <= NSTG; k++) begin : g_stage
    for (genvar a = 0; a < 2; a++) begin : g_axis
      logic [REM_W:0] trial;
      logic [REM_W:0] diff;
      logic           ge;

      always_comb begin
        trial = {rem_r[k-1][a], mag_r[k-1][a][MAG_W-1]};
        diff  = trial - {1'b0, cfg.cell_scale};
        ge    = trial >= {1'b0, cfg.cell_scale};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][a]  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
          mag_r[k][a]  <= mag_r[k-1][a] << 1;
          neg_r[k][a]  <= neg_r[k-1][a];
          qbit_r[k][a] <= ge;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= valid_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        colors_r[k] <= colors_r[k-1];
      end
    end
  end

  // Floor quotient of a negative sum with a remainder is -(t+1): its parity flips.
  logic par_x, par_y;
  assign par_x = qbit_r[NSTG][0] ^ (neg_r[NSTG][0] & (|rem_r[NSTG][0]));
  assign par_y = qbit_r[NSTG][1] ^ (neg_r[NSTG][1] & (|rem_r[NSTG][1]));

  assign out_valid  = valid_r[NSTG];
  assign out_parity = par_x ^ par_y;
  assign colors_out = colors_r[NSTG];

endmodule

// ----- rtl/dcp_luma_out.sv -----
module dcp_luma_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic                        parity,
  input  dcp_pkg::color_pair_t        colors,
  output logic                        out_valid,
  output logic [dcp_pkg::COLOR_W-1:0] color_out,
  output logic [dcp_pkg::GRAY_W-1:0]  gray_out
);
  import dcp_pkg::*;

  logic [COLOR_W-1:0] sel_color;
  logic [WSUM_W-1:0]  wsum;
  logic               sel_valid_r;
  logic [COLOR_W-1:0] sel_color_r;
  logic [WSUM_W-1:0]  wsum_r;
  logic [PROD_W-1:0]  prod;
  logic               out_valid_r;
  logic [COLOR_W-1:0] color_r;
  logic [GRAY_W-1:0]  gray_r;

  always_comb begin
    sel_color = parity ? colors.second_color : colors.first_color;
    wsum = WSUM_W'(sel_color[31:24]) * LUMA_R
         + WSUM_W'(sel_color[23:16]) * LUMA_G
         + WSUM_W'(sel_color[15:8])  * LUMA_B;
  end

  assign prod = PROD_W'(wsum_r) * PROD_W'(RECIP_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      sel_valid_r <= in_valid;
      out_valid_r <= sel_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_color_r <= sel_color;
      wsum_r      <= wsum;
      color_r     <= sel_color_r;
      gray_r      <= prod[RECIP_SHIFT +: GRAY_W];
    end
  end

  assign out_valid = out_valid_r;
  assign color_out = color_r;
  assign gray_out  = gray_r;

endmodule

// ----- rtl/distorted_checker_pixel.sv -----
// Distorted checkerboard pixel generator.
// Input channel in_ch carries one pixel word: coordinates, a signed distortion
// offset and two RGBA colors. Output channel out_ch carries one result word per
// input word: the chosen color and its truncated luma. Both use valid/ready; a
// word moves at a clock edge where valid and ready are both high.
// The APB-style port sets the cell scale (byte address 0) and the distortion
// enable (byte address 4). Change them only while the pipeline is empty.
// One stage forms the distorted coordinates, COORD_WIDTH + 1 stages run a
// restoring division one quotient bit each, one stage selects the color and
// weights the channels, and the output register applies the divide by 1000.
// Throughput is one word per clock. When the receiver holds ready low while a
// result waits, the whole pipeline holds and in_ch.ready drops; every stage
// keeps its word until the result is taken, so nothing is lost or repeated.
// Synchronous reset clears all valid bits, sets the scale to 1 and turns
// distortion off.
module distorted_checker_pixel #(
  parameter int COORD_WIDTH = dcp_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dcp_in_if.sink                         in_ch,
  dcp_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dcp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dcp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [dcp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import dcp_pkg::*;

  cfg_t        cfg;
  color_pair_t colors_in;
  color_pair_t colors_mid;
  logic        mid_valid;
  logic        mid_parity;
  logic        en;

  // The pipeline advances unless a finished result is waiting on the receiver.
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  assign colors_in.first_color  = in_ch.first_color;
  assign colors_in.second_color = in_ch.second_color;

  dcp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Cell index parity of both axes from the floor-divided coordinates.
  dcp_parity_pipe #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_parity (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_ch.valid),
    .pixel_x    (in_ch.pixel_x),
    .pixel_y    (in_ch.pixel_y),
    .offset_x   (in_ch.offset_x),
    .offset_y   (in_ch.offset_y),
    .colors_in  (colors_in),
    .cfg        (cfg),
    .out_valid  (mid_valid),
    .out_parity (mid_parity),
    .colors_out (colors_mid)
  );

  // Color choice and luma, ending in the output register.
  dcp_luma_out u_luma (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (mid_valid),
    .parity    (mid_parity),
    .colors    (colors_mid),
    .out_valid (out_ch.valid),
    .color_out (out_ch.color_out),
    .gray_out  (out_ch.gray_out)
  );

endmodule
